@@ sv/tcw_pkg.sv @@
package tcw_pkg;

    // Grid geometry
    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int TERMINALS   = 3;
    localparam int GRID_CELLS  = ROWS * COLUMNS;
    localparam int TOTAL_CELLS = TERMINALS * GRID_CELLS;
    localparam int ADDR_W      = $clog2(TOTAL_CELLS);
    localparam int GRID_W      = $clog2(GRID_CELLS);
    localparam int TIDX_W      = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;

    // Field widths
    localparam int CMD_W  = 2;
    localparam int TERM_W = 2;
    localparam int CHAR_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int ATTR_W = 8;

    localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [CHAR_W-1:0] RETURN_CHAR  = 8'h0D;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT       = 2'd0,
        CMD_BACKSPACE = 2'd1,
        CMD_CLEAR     = 2'd2,
        CMD_READ      = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_FILL,
        ST_DONE
    } state_t;

    typedef struct packed {
        cmd_t              command;
        logic [TERM_W-1:0] terminal;
        logic [CHAR_W-1:0] character;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_column;
    } item_t;

    typedef struct packed {
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_column;
        logic              scrolled;
        logic [CHAR_W-1:0] cell_char;
    } res_t;

endpackage

@@ sv/tcw_cell_ram.sv @@
module tcw_cell_ram #(
    parameter int DEPTH  = 6000,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/tcw_sequencer.sv @@
module tcw_sequencer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  tcw_pkg::item_t               in_item,
    output logic                         res_valid,
    input  logic                         res_ready,
    output tcw_pkg::res_t                res,
    output logic                         mem_wr_en,
    output logic [tcw_pkg::ADDR_W-1:0]   mem_wr_addr,
    output logic [tcw_pkg::CHAR_W-1:0]   mem_wr_data,
    output logic                         mem_rd_en,
    output logic [tcw_pkg::ADDR_W-1:0]   mem_rd_addr,
    input  logic [tcw_pkg::CHAR_W-1:0]   mem_rd_data
);

    import tcw_pkg::*;

    function automatic logic [ADDR_W-1:0] grid_offset(input logic [ROW_W-1:0] r,
                                                      input logic [COL_W-1:0] c);
        grid_offset = ADDR_W'(32'(r) * COLUMNS + 32'(c));
    endfunction

    state_t            state_reg, state_next;
    item_t             item_reg;
    logic [TERM_W-1:0] term_reg;
    logic [GRID_W-1:0] idx_reg;
    res_t              res_reg;
    logic [ROW_W-1:0]  cursor_row_reg [TERMINALS];
    logic [COL_W-1:0]  cursor_col_reg [TERMINALS];

    logic              term_ok;
    logic [TIDX_W-1:0] tidx;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] sweep_addr;
    logic [ROW_W-1:0]  cur_row;
    logic [COL_W-1:0]  cur_col;
    logic              idx_grid_last;
    logic              idx_copy_last;
    logic              init_last_term;

    // Decoded action of the item in the execute cycle
    logic              ex_newline;
    logic [ROW_W-1:0]  ex_row;
    logic [COL_W-1:0]  ex_col;
    logic              ex_scroll;
    logic              ex_wr;
    logic [ROW_W-1:0]  ex_wr_row;
    logic [COL_W-1:0]  ex_wr_col;
    logic [CHAR_W-1:0] ex_wr_data;
    logic              ex_rd;

    assign term_ok        = 32'(term_reg) < TERMINALS;
    assign tidx           = term_ok ? term_reg[TIDX_W-1:0] : '0;
    assign base           = ADDR_W'(32'(term_reg) * GRID_CELLS);
    assign sweep_addr     = base + ADDR_W'(idx_reg);
    assign cur_row        = cursor_row_reg[tidx];
    assign cur_col        = cursor_col_reg[tidx];
    assign idx_grid_last  = 32'(idx_reg) == GRID_CELLS - 1;
    assign idx_copy_last  = 32'(idx_reg) == GRID_CELLS - COLUMNS - 1;
    assign init_last_term = 32'(term_reg) == TERMINALS - 1;
    assign ex_newline     = (item_reg.character == NEWLINE_CHAR) ||
                            (item_reg.character == RETURN_CHAR);

    always_comb
    begin
        ex_row     = cur_row;
        ex_col     = cur_col;
        ex_scroll  = 1'b0;
        ex_wr      = 1'b0;
        ex_wr_row  = cur_row;
        ex_wr_col  = cur_col;
        ex_wr_data = item_reg.character;
        ex_rd      = 1'b0;
        unique case (item_reg.command)
            CMD_PUT:
            begin
                if (ex_newline)
                begin
                    ex_col = '0;
                    if (32'(cur_row) == ROWS - 1)
                    begin
                        ex_scroll = 1'b1;
                    end
                    else
                    begin
                        ex_row = cur_row + 1'b1;
                    end
                end
                else
                begin
                    ex_wr = 1'b1;
                    if (32'(cur_col) == COLUMNS - 1)
                    begin
                        ex_col = '0;
                        if (32'(cur_row) == ROWS - 1)
                        begin
                            ex_scroll = 1'b1;
                        end
                        else
                        begin
                            ex_row = cur_row + 1'b1;
                        end
                    end
                    else
                    begin
                        ex_col = cur_col + 1'b1;
                    end
                end
            end
            CMD_BACKSPACE:
            begin
                ex_wr_data = SPACE_CHAR;
                if (cur_col == '0)
                begin
                    if (cur_row != '0)
                    begin
                        ex_row = cur_row - 1'b1;
                        ex_col = COL_W'(COLUMNS - 1);
                        ex_wr  = 1'b1;
                    end
                end
                else
                begin
                    ex_col = cur_col - 1'b1;
                    ex_wr  = 1'b1;
                end
                ex_wr_row = ex_row;
                ex_wr_col = ex_col;
            end
            CMD_CLEAR:
            begin
                ex_row = '0;
                ex_col = '0;
            end
            CMD_READ:
            begin
                ex_rd = (32'(item_reg.read_row) < ROWS) &&
                        (32'(item_reg.read_column) < COLUMNS);
            end
            default:
            begin
                ex_rd = 1'b0;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (idx_grid_last && init_last_term)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                priority if (!term_ok)
                begin
                    state_next = ST_DONE;
                end
                else if (item_reg.command == CMD_CLEAR)
                begin
                    state_next = ST_FILL;
                end
                else if (ex_rd)
                begin
                    state_next = ST_READ;
                end
                else if (ex_scroll)
                begin
                    state_next = ST_COPY_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                state_next = ST_DONE;
            end
            ST_COPY_RD:
            begin
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR:
            begin
                state_next = idx_copy_last ? ST_FILL : ST_COPY_RD;
            end
            ST_FILL:
            begin
                if (idx_grid_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and memory port drive
    always_comb
    begin
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = sweep_addr;
        mem_wr_data = SPACE_CHAR;
        mem_rd_en   = 1'b0;
        mem_rd_addr = base + grid_offset(item_reg.read_row, item_reg.read_column);
        unique case (state_reg)
            ST_INIT:
            begin
                mem_wr_en = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_EXEC:
            begin
                mem_wr_en   = term_ok && ex_wr;
                mem_wr_addr = base + grid_offset(ex_wr_row, ex_wr_col);
                mem_wr_data = ex_wr_data;
                mem_rd_en   = term_ok && ex_rd;
            end
            ST_READ:
            begin
                mem_rd_en = 1'b0;
            end
            ST_COPY_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = sweep_addr + ADDR_W'(COLUMNS);
            end
            ST_COPY_WR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_data = mem_rd_data;
            end
            ST_FILL:
            begin
                mem_wr_en = 1'b1;
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    assign res = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            term_reg  <= '0;
            idx_reg   <= '0;
            for (int t = 0; t < TERMINALS; t++)
            begin
                cursor_row_reg[t] <= '0;
                cursor_col_reg[t] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_INIT:
                begin
                    // Walk each terminal's grid in turn
                    if (idx_grid_last)
                    begin
                        idx_reg  <= '0;
                        term_reg <= term_reg + 1'b1;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        term_reg <= in_item.terminal;
                    end
                end
                ST_EXEC:
                begin
                    idx_reg <= '0;
                    if (term_ok)
                    begin
                        cursor_row_reg[tidx] <= ex_row;
                        cursor_col_reg[tidx] <= ex_col;
                    end
                end
                ST_COPY_WR, ST_FILL:
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                ST_READ, ST_COPY_RD, ST_DONE:
                begin
                    idx_reg <= idx_reg;
                end
                default:
                begin
                    idx_reg <= idx_reg;
                end
            endcase
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            item_reg <= in_item;
        end
        if (state_reg == ST_EXEC)
        begin
            res_reg.cursor_row    <= term_ok ? ex_row : '0;
            res_reg.cursor_column <= term_ok ? ex_col : '0;
            res_reg.scrolled      <= term_ok && ex_scroll;
            res_reg.cell_char     <= '0;
        end
        if (state_reg == ST_READ)
        begin
            res_reg.cell_char <= mem_rd_data;
        end
    end

endmodule

@@ sv/text_console_cell_writer.sv @@
// Text console cell writer: a character grid and cursor per terminal.
//
// Input channel (in_valid/in_ready) takes one word per command: put,
// backspace, clear or read cell, addressed to one terminal. Each word gives
// exactly one result word on the output channel (out_valid/out_ready) with
// the cursor after the command, a scroll flag, the cell read and the
// configured attribute. The config channel (cfg_valid/cfg_ready/cfg_data)
// sets the attribute; it is always ready.
//
// Operation: items are handled one at a time by a sequencer around a single
// port-pair cell RAM (one write, one registered read per cycle). Clear walks
// the grid at one cell a cycle. A scroll copies every cell of rows 1 to
// ROWS-1 up one row, a read and then a write per cell, then blanks the
// bottom row. A finished result waits in the sequencer's DONE state until
// the output register takes it; out_valid comes from that register.
// Reset: cursors home, attribute 7, then a blanking pass over all
// TERMINALS*ROWS*COLUMNS cells (6000 by default) with in_ready low.
// A stalled receiver: the output register holds the result, the next item
// is still accepted and worked, and only its result waits for the slot.
module text_console_cell_writer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [tcw_pkg::CMD_W-1:0]   command,
    input  logic [tcw_pkg::TERM_W-1:0]  terminal,
    input  logic [tcw_pkg::CHAR_W-1:0]  character,
    input  logic [tcw_pkg::ROW_W-1:0]   read_row,
    input  logic [tcw_pkg::COL_W-1:0]   read_column,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [tcw_pkg::ROW_W-1:0]   cursor_row,
    output logic [tcw_pkg::COL_W-1:0]   cursor_column,
    output logic                        scrolled,
    output logic [tcw_pkg::CHAR_W-1:0]  cell_char,
    output logic [tcw_pkg::ATTR_W-1:0]  cell_attr,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tcw_pkg::ATTR_W-1:0]  cfg_data
);

    import tcw_pkg::*;

    item_t             in_item;
    res_t              res;
    logic              res_valid;
    logic              res_ready;
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [CHAR_W-1:0] mem_wr_data;
    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic [CHAR_W-1:0] mem_rd_data;

    logic [ATTR_W-1:0] attr_reg;
    logic              out_valid_reg;
    res_t              out_res_reg;
    logic [ATTR_W-1:0] out_attr_reg;

    // Pack the input word for the sequencer
    assign in_item.command     = cmd_t'(command);
    assign in_item.terminal    = terminal;
    assign in_item.character   = character;
    assign in_item.read_row    = read_row;
    assign in_item.read_column = read_column;

    tcw_sequencer u_sequencer (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    tcw_cell_ram #(
        .DEPTH  (TOTAL_CELLS),
        .WIDTH  (CHAR_W),
        .ADDR_W (ADDR_W)
    ) u_cell_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Attribute register: take every config word
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_RESET;
        end
        else if (cfg_valid)
        begin
            attr_reg <= cfg_data;
        end
    end

    // Output register: load a finished result once the slot is empty or drains
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg  <= res;
            out_attr_reg <= attr_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cursor_row    = out_res_reg.cursor_row;
    assign cursor_column = out_res_reg.cursor_column;
    assign scrolled      = out_res_reg.scrolled;
    assign cell_char     = out_res_reg.cell_char;
    assign cell_attr     = out_attr_reg;

endmodule
